// ===== hw/rtl/pos_pkg.sv =====
// Package with the shared types and constants of the push-once stack.
package pos_pkg;

  localparam int unsigned MAX_STATES = 1024;
  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned ADDR_BITS  = $clog2(MAX_STATES);
  localparam int unsigned DEPTH_BITS = $clog2(MAX_STATES + 1);
  localparam int unsigned CMD_BITS   = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sweep;
    logic execute;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pos_if.sv =====
// Request and response channel interfaces of the push-once stack.
interface pos_req_if;
  logic                            valid;
  logic                            ready;
  logic [pos_pkg::CMD_BITS-1:0]    cmd;
  logic [pos_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface pos_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pos_pkg::VALUE_BITS-1:0]  popped_value;
  logic                            was_marked;
  logic                            stack_empty;
  logic [pos_pkg::DEPTH_BITS-1:0]  depth;

  modport source (output valid, output popped_value, output was_marked,
                  output stack_empty, output depth, input ready);
  modport sink   (input valid, input popped_value, input was_marked,
                  input stack_empty, input depth, output ready);
endinterface

// ===== hw/rtl/pos_ctrl.sv =====
// Controller state machine of the push-once stack: sweep, accept, execute.
module pos_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [pos_pkg::CMD_BITS-1:0] req_cmd_i,
  output logic                         req_ready_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output pos_pkg::ctrl_cmd_t           cmd_o,
  input  pos_pkg::dp_stat_t            stat_i
);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   clr_pend_q, clr_pend_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   accept, execute;

  assign accept  = (state_q == ST_IDLE) && req_valid_i;
  assign execute = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready_i);

  always_comb begin
    state_d    = state_q;
    clr_pend_d = clr_pend_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (stat_i.sweep_last) begin
          state_d = clr_pend_q ? ST_EXEC : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_cmd_i == pos_pkg::CMD_CLEAR) begin
            state_d    = ST_SWEEP;
            clr_pend_d = 1'b1;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (execute) begin
          state_d    = ST_IDLE;
          clr_pend_d = 1'b0;
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (execute) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  // After reset the mark bitmap is swept to zero before any request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      clr_pend_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_pend_q  <= clr_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o   = (state_q == ST_IDLE);
  assign rsp_valid_o   = rsp_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.sweep   = (state_q == ST_SWEEP);
  assign cmd_o.execute = execute;

endmodule

// ===== hw/rtl/pos_dp.sv =====
// Datapath of the push-once stack: stack memory, mark bitmap, depth and result register.
module pos_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pos_pkg::ctrl_cmd_t             cmd_i,
  output pos_pkg::dp_stat_t              stat_o,
  input  logic [pos_pkg::CMD_BITS-1:0]   req_cmd_i,
  input  logic [pos_pkg::VALUE_BITS-1:0] req_value_i,
  output logic [pos_pkg::VALUE_BITS-1:0] popped_value_o,
  output logic                           was_marked_o,
  output logic                           stack_empty_o,
  output logic [pos_pkg::DEPTH_BITS-1:0] depth_o
);

  localparam logic [pos_pkg::DEPTH_BITS-1:0] DepthOne = pos_pkg::DEPTH_BITS'(1);
  localparam logic [pos_pkg::DEPTH_BITS-1:0] DepthMax =
    pos_pkg::DEPTH_BITS'(pos_pkg::MAX_STATES);
  localparam logic [pos_pkg::ADDR_BITS-1:0]  SweepLast =
    pos_pkg::ADDR_BITS'(pos_pkg::MAX_STATES - 1);

  logic [pos_pkg::VALUE_BITS-1:0] stack_mem [pos_pkg::MAX_STATES];
  logic                           mark_mem  [pos_pkg::MAX_STATES];

  pos_pkg::cmd_e                  item_cmd_q;
  logic [pos_pkg::VALUE_BITS-1:0] item_value_q;
  logic [pos_pkg::DEPTH_BITS-1:0] depth_q, depth_d;
  logic [pos_pkg::ADDR_BITS-1:0]  sweep_cnt_q;
  logic                           mark_rd_q;
  logic [pos_pkg::VALUE_BITS-1:0] stack_rd_q;

  logic [pos_pkg::DEPTH_BITS-1:0] depth_dec;
  logic                           in_range;
  logic                           push_we;
  logic [pos_pkg::VALUE_BITS-1:0] popped_d;
  logic                           marked_d;
  logic                           empty_d;

  logic [pos_pkg::VALUE_BITS-1:0] popped_q;
  logic                           marked_q;
  logic                           empty_q;
  logic [pos_pkg::DEPTH_BITS-1:0] rsp_depth_q;

  assign depth_dec = depth_q - DepthOne;
  assign in_range  = pos_pkg::DEPTH_BITS'(item_value_q) < DepthMax;

  // Item register; the memories are read in the same cycle as the request is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_cmd_q   <= pos_pkg::cmd_e'(req_cmd_i);
      item_value_q <= req_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mark_rd_q  <= mark_mem[req_value_i[pos_pkg::ADDR_BITS-1:0]];
      stack_rd_q <= stack_mem[depth_dec[pos_pkg::ADDR_BITS-1:0]];
    end
  end

  always_comb begin
    depth_d  = depth_q;
    push_we  = 1'b0;
    popped_d = '0;
    marked_d = 1'b0;
    empty_d  = 1'b0;
    unique case (item_cmd_q)
      pos_pkg::CMD_PUSH: begin
        if (in_range) begin
          if (mark_rd_q) begin
            marked_d = 1'b1;
          end else if (depth_q < DepthMax) begin
            push_we = 1'b1;
            depth_d = depth_q + DepthOne;
          end
        end
      end
      pos_pkg::CMD_POP: begin
        if (depth_q == '0) begin
          empty_d = 1'b1;
        end else begin
          depth_d  = depth_dec;
          popped_d = stack_rd_q;
        end
      end
      pos_pkg::CMD_QUERY: begin
        marked_d = in_range && mark_rd_q;
      end
      pos_pkg::CMD_CLEAR: begin
        depth_d = '0;
      end
      default: depth_d = depth_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && push_we) begin
      stack_mem[depth_q[pos_pkg::ADDR_BITS-1:0]] <= item_value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mark_mem[sweep_cnt_q] <= 1'b0;
    end else if (cmd_i.execute && push_we) begin
      mark_mem[item_value_q[pos_pkg::ADDR_BITS-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      sweep_cnt_q <= '0;
    end else begin
      if (cmd_i.execute) begin
        depth_q <= depth_d;
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_q + pos_pkg::ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      popped_q    <= popped_d;
      marked_q    <= marked_d;
      empty_q     <= empty_d;
      rsp_depth_q <= depth_d;
    end
  end

  assign stat_o.sweep_last = (sweep_cnt_q == SweepLast);
  assign popped_value_o    = popped_q;
  assign was_marked_o      = marked_q;
  assign stack_empty_o     = empty_q;
  assign depth_o           = rsp_depth_q;

endmodule

// ===== hw/rtl/push_once_stack_top.sv =====
// Top level of the push-once stack: controller, datapath and channel ports.
//
//   Channel  Direction  Handshake      Payload
//   req_i    in         valid / ready  cmd, value
//   rsp_o    out        valid / ready  popped_value, was_marked, stack_empty, depth
//
// Push, pop and query pass through the request cycle, in which the mark bitmap
// and the stack memory are read into registers, and then an execute cycle.
// A clear first sweeps the bitmap to zero, one bit a cycle, and then executes.
// After reset req_i.ready stays low while the bitmap is swept.
// A response waits in the output register while the next request is taken; a
// request stalls in its execute cycle until the previous response has gone.
module push_once_stack_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pos_req_if.sink   req_i,
  pos_rsp_if.source rsp_o
);

  pos_pkg::ctrl_cmd_t ctrl_cmd;
  pos_pkg::dp_stat_t  dp_stat;

  pos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (ctrl_cmd),
    .stat_i      (dp_stat)
  );

  pos_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .req_cmd_i      (req_i.cmd),
    .req_value_i    (req_i.value),
    .popped_value_o (rsp_o.popped_value),
    .was_marked_o   (rsp_o.was_marked),
    .stack_empty_o  (rsp_o.stack_empty),
    .depth_o        (rsp_o.depth)
  );

endmodule

// ===== hw/rtl/pos_chk.sv =====
// Port-level assertion checker for the push-once stack, bound to the top level.
module pos_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [pos_pkg::VALUE_BITS-1:0] popped_value_i,
  input logic                           was_marked_i,
  input logic                           stack_empty_i,
  input logic [pos_pkg::DEPTH_BITS-1:0] depth_i
);

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(popped_value_i)
      && $stable(depth_i) && $stable(was_marked_i) && $stable(stack_empty_i))
    else $error("response changed while stalled");

  // Only one request is in flight: ready drops right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in progress");

  // An empty pop returns nothing and leaves the stack empty.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && stack_empty_i |->
      popped_value_i == '0 && depth_i == '0 && !was_marked_i)
    else $error("empty pop with non-zero fields");

  // The depth never exceeds the bitmap size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> depth_i <= pos_pkg::DEPTH_BITS'(pos_pkg::MAX_STATES))
    else $error("depth beyond capacity");

endmodule

bind push_once_stack_top pos_chk u_pos_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .popped_value_i (rsp_o.popped_value),
  .was_marked_i   (rsp_o.was_marked),
  .stack_empty_i  (rsp_o.stack_empty),
  .depth_i        (rsp_o.depth)
);

// ===== sim/push_once_stack_top_tb.sv =====
// Testbench for the push-once stack: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module push_once_stack_top_tb;

  localparam int unsigned ITEMS = 1050;

  typedef struct packed {
    logic [pos_pkg::VALUE_BITS-1:0] popped;
    logic                           marked;
    logic                           empty;
    logic [pos_pkg::DEPTH_BITS-1:0] depth;
  } answer_t;

  class worklist_scoreboard;
    bit                             marks   [pos_pkg::MAX_STATES];
    logic [pos_pkg::VALUE_BITS-1:0] entries [pos_pkg::MAX_STATES];
    int unsigned                    fill;
    answer_t                        answer_q[$];
    int unsigned                    errors;

    function void note_request(pos_pkg::cmd_e c, logic [pos_pkg::VALUE_BITS-1:0] v);
      answer_t a;
      a = '0;
      case (c)
        pos_pkg::CMD_PUSH: begin
          if (marks[v]) begin
            a.marked = 1'b1;
          end else if (fill < pos_pkg::MAX_STATES) begin
            entries[fill] = v;
            fill++;
            marks[v] = 1'b1;
          end
        end
        pos_pkg::CMD_POP: begin
          if (fill == 0) begin
            a.empty = 1'b1;
          end else begin
            fill--;
            a.popped = entries[fill];
          end
        end
        pos_pkg::CMD_QUERY: begin
          a.marked = marks[v];
        end
        default: begin
          foreach (marks[i]) marks[i] = 1'b0;
          fill = 0;
        end
      endcase
      a.depth = pos_pkg::DEPTH_BITS'(fill);
      answer_q.push_back(a);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (answer_q.size() == 0) begin
        $error("response arrived with no request waiting for it");
        errors++;
        return;
      end
      want = answer_q.pop_front();
      check_field("popped_value", 16'(want.popped), 16'(got.popped));
      check_field("was_marked", 16'(want.marked), 16'(got.marked));
      check_field("stack_empty", 16'(want.empty), 16'(got.empty));
      check_field("depth", 16'(want.depth), 16'(got.depth));
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pos_req_if req_if ();
  pos_rsp_if rsp_if ();

  push_once_stack_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  worklist_scoreboard board = new();
  int unsigned sent_count;
  int unsigned rsp_count;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The sender never idles for a stretch in the middle of the random part.
  task automatic send_request(pos_pkg::cmd_e c, logic [pos_pkg::VALUE_BITS-1:0] v);
    bit calm;
    calm = (sent_count >= 300) && (sent_count < 500);
    while (!calm && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= c;
    req_if.value <= v;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(c, v);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic run_random_phase(int unsigned length);
    bit          narrow;
    bit          burst;
    int unsigned pushes;
    int unsigned r;
    logic [pos_pkg::VALUE_BITS-1:0] v;
    narrow = ($urandom_range(2) == 0);
    burst  = ($urandom_range(3) == 0);
    if (burst) begin
      // Build the stack up deep, then drain it partway, past empty only where duplicate pushes were refused.
      pushes = $urandom_range(400, 50);
      if (pushes > (ITEMS - sent_count) * 2 / 3) pushes = (ITEMS - sent_count) * 2 / 3;
      repeat (pushes) begin
        v = narrow ? pos_pkg::VALUE_BITS'($urandom_range(63))
                   : pos_pkg::VALUE_BITS'($urandom_range(1023));
        send_request(pos_pkg::CMD_PUSH, v);
      end
      repeat (pushes / 2 + $urandom_range(8)) begin
        send_request(pos_pkg::CMD_POP, pos_pkg::VALUE_BITS'($urandom));
      end
    end else begin
      repeat (length) begin
        r = $urandom_range(99);
        v = narrow ? pos_pkg::VALUE_BITS'($urandom_range(31))
                   : pos_pkg::VALUE_BITS'($urandom_range(1023));
        if (r < 55) send_request(pos_pkg::CMD_PUSH, v);
        else if (r < 78) send_request(pos_pkg::CMD_POP, v);
        else if (r < 99) send_request(pos_pkg::CMD_QUERY, v);
        else send_request(pos_pkg::CMD_CLEAR, v);
      end
    end
    if ($urandom_range(1) == 0) send_request(pos_pkg::CMD_CLEAR, pos_pkg::VALUE_BITS'($urandom));
  endtask

  initial begin : sender
    int unsigned left;
    req_if.valid = 1'b0;
    req_if.cmd   = pos_pkg::CMD_PUSH;
    req_if.value = '0;
    rst_n = 1'b0;
    sent_count = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: value zero, the extremes, duplicates, empty pops and clears.
    send_request(pos_pkg::CMD_QUERY, 10'd0);
    send_request(pos_pkg::CMD_PUSH, 10'd0);
    send_request(pos_pkg::CMD_PUSH, 10'd0);
    send_request(pos_pkg::CMD_QUERY, 10'd0);
    send_request(pos_pkg::CMD_PUSH, 10'd1023);
    send_request(pos_pkg::CMD_PUSH, 10'd1023);
    send_request(pos_pkg::CMD_QUERY, 10'd1023);
    send_request(pos_pkg::CMD_PUSH, 10'h155);
    send_request(pos_pkg::CMD_PUSH, 10'h2AA);
    send_request(pos_pkg::CMD_POP, 10'h3FF);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_PUSH, 10'd0);
    send_request(pos_pkg::CMD_QUERY, 10'd512);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_CLEAR, 10'h3FF);
    send_request(pos_pkg::CMD_QUERY, 10'd0);
    send_request(pos_pkg::CMD_QUERY, 10'd1023);
    send_request(pos_pkg::CMD_PUSH, 10'd0);
    send_request(pos_pkg::CMD_POP, 10'd0);
    send_request(pos_pkg::CMD_CLEAR, 10'd0);
    send_request(pos_pkg::CMD_POP, 10'd0);

    while (sent_count < ITEMS) begin
      left = ITEMS - sent_count;
      run_random_phase(left < 150 ? left : $urandom_range(150, 20));
    end
    req_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[push_once_stack_top] OK");
    end else begin
      $display("[push_once_stack_top] ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off that fills the block.
  initial begin : receiver
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && rsp_count >= 700) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_count >= 300 && rsp_count < 500) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.popped = rsp_if.popped_value;
      got.marked = rsp_if.was_marked;
      got.empty  = rsp_if.stack_empty;
      got.depth  = rsp_if.depth;
      board.check_answer(got);
      rsp_count++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("[push_once_stack_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pos_pkg.sv
hw/rtl/pos_if.sv
hw/rtl/pos_ctrl.sv
hw/rtl/pos_dp.sv
hw/rtl/push_once_stack_top.sv
hw/rtl/pos_chk.sv
sim/push_once_stack_top_tb.sv
